>>> rtl/core/rti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection package
// Shared widths, payload structs, register codes and helper functions.
// ----------------------------------------------------------------------------
package rti_pkg;

    // Input coordinate format and result format.
    localparam int CW = 16;
    localparam int CF = 8;
    localparam int RW = 32;
    localparam int RF = 16;

    // Intermediate widths: edges, cross products, dot products.
    localparam int EW  = CW + 1;
    localparam int PW  = 2 * CW + 2;
    localparam int QW  = 2 * CW + 3;
    localparam int NW  = 3 * CW + 6;
    localparam int RMW = NW + 1;

    // Quotient bits below the saturation point, and the matching shift.
    localparam int DIV_N  = RW - 1;
    localparam int SAT_SH = RW - 1 - RF;

    // Hit point arithmetic width.
    localparam int MW = RW + CW;
    localparam int SW = MW + 1;

    // Configuration port.
    localparam int CFG_W     = 3 * CW;
    localparam int CFG_IDX_W = 2;
    localparam int EPS_W     = 16;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic signed [RW-1:0] T_MAX = {1'b0, {(RW-1){1'b1}}};
    localparam logic signed [RW-1:0] T_MIN = {1'b1, {(RW-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERTEX_A = 2'd0,
        REG_VERTEX_B = 2'd1,
        REG_VERTEX_C = 2'd2,
        REG_DET_EPS  = 2'd3
    } t_reg_idx;

    typedef logic signed [CW-1:0] t_coord;

    // x sits in the low bits so a vertex register maps straight onto it.
    typedef struct packed {
        t_coord z;
        t_coord y;
        t_coord x;
    } t_vec;

    typedef struct packed {
        logic signed [EW-1:0] z;
        logic signed [EW-1:0] y;
        logic signed [EW-1:0] x;
    } t_evec;

    typedef struct packed {
        logic signed [PW-1:0] z;
        logic signed [PW-1:0] y;
        logic signed [PW-1:0] x;
    } t_pvec;

    typedef struct packed {
        logic signed [QW-1:0] z;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] x;
    } t_qvec;

    typedef struct packed {
        t_vec a;
        t_vec b;
        t_vec c;
    } t_tri;

    // Per-ray status that rides along the back end.
    typedef struct packed {
        logic hit;
        logic sat;
        logic neg;
        t_vec origin;
        t_vec dir;
    } t_side;

    // One classified ray, as held in the queue.
    typedef struct packed {
        t_side           side;
        logic [NW-1:0]   det;
        logic [NW-1:0]   mag;
    } t_cls;

    function automatic t_evec vsub(input t_vec a, input t_vec b);
        t_evec r;
        r.x = EW'(a.x) - EW'(b.x);
        r.y = EW'(a.y) - EW'(b.y);
        r.z = EW'(a.z) - EW'(b.z);
        return r;
    endfunction

    function automatic logic signed [RW-1:0] sat_res(input logic signed [SW-1:0] v);
        logic signed [RW-1:0] r;
        if (v > SW'(T_MAX)) begin
            r = T_MAX;
        end else if (v < SW'(T_MIN)) begin
            r = T_MIN;
        end else begin
            r = v[RW-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/rti_ray_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray channel
// Valid/ready channel carrying one ray (origin and direction) per beat.
// ----------------------------------------------------------------------------
interface rti_ray_if;
    logic               valid;
    logic               ready;
    rti_pkg::t_coord    origin_x;
    rti_pkg::t_coord    origin_y;
    rti_pkg::t_coord    origin_z;
    rti_pkg::t_coord    dir_x;
    rti_pkg::t_coord    dir_y;
    rti_pkg::t_coord    dir_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

>>> rtl/core/rti_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one intersection result per beat.
// ----------------------------------------------------------------------------
interface rti_res_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic signed [rti_pkg::RW-1:0]  hit_distance;
    logic signed [rti_pkg::RW-1:0]  hit_point_x;
    logic signed [rti_pkg::RW-1:0]  hit_point_y;
    logic signed [rti_pkg::RW-1:0]  hit_point_z;

    modport source (
        output valid, hit, hit_distance, hit_point_x, hit_point_y, hit_point_z,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_distance, hit_point_x, hit_point_y, hit_point_z,
        output ready
    );
endinterface

>>> rtl/core/ray_triangle_intersect_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection core
// Tests a stream of rays against one triangle held in configuration.
// ----------------------------------------------------------------------------
// Usage: rays arrive on i_ray, one beat per ray, each with a signed Q8.8
// origin and direction. The triangle vertices and the determinant threshold
// are written through the i_cfg_* port while the core is idle. Every ray
// yields exactly one beat on o_res: a hit flag, the distance t and the hit
// point in signed Q16.16, all zero on a miss.
// Throughput is one ray per cycle while the receiver does not stall. From
// the input beat to the result beat a ray passes five front-end stages,
// the queue, a divider load stage, 31 divider stages (one quotient bit
// each) and three stages for t, the hit point multiply and the output
// register.
// A stalled receiver holds the back end; the four-entry queue then absorbs
// rays until it fills, and only then does i_ray.ready drop.
// Synchronous reset empties the pipelines and the queue and restores the
// default triangle (A at the origin, B at 4.0 on x, C at 4.0 on y) with a
// threshold of one determinant LSB.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rti_pkg::CFG_W-1:0]           i_cfg_data,
    rti_ray_if.sink                             i_ray,
    rti_res_if.source                           o_res
);

    logic [rti_pkg::CFG_W-1:0]  r_vtx_a;
    logic [rti_pkg::CFG_W-1:0]  r_vtx_b;
    logic [rti_pkg::CFG_W-1:0]  r_vtx_c;
    logic [rti_pkg::EPS_W-1:0]  r_eps;
    rti_pkg::t_tri              tri_cfg;

    logic                       f_valid;
    logic                       f_ready;
    rti_pkg::t_cls              f_cls;
    logic                       q_valid;
    logic                       q_ready;
    rti_pkg::t_cls              q_cls;

    // Configuration registers. Every index of the port maps to a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx_a <= rti_pkg::CFG_W'(0);
            r_vtx_b <= rti_pkg::CFG_W'(1024);
            r_vtx_c <= rti_pkg::CFG_W'(67108864);
            r_eps   <= rti_pkg::EPS_W'(1);
        end else if (i_cfg_we) begin
            case (rti_pkg::t_reg_idx'(i_cfg_idx))
                rti_pkg::REG_VERTEX_A: begin
                    r_vtx_a <= i_cfg_data;
                end
                rti_pkg::REG_VERTEX_B: begin
                    r_vtx_b <= i_cfg_data;
                end
                rti_pkg::REG_VERTEX_C: begin
                    r_vtx_c <= i_cfg_data;
                end
                rti_pkg::REG_DET_EPS: begin
                    r_eps <= i_cfg_data[rti_pkg::EPS_W-1:0];
                end
                default: begin
                    r_eps <= r_eps;
                end
            endcase
        end
    end

    // Vertex registers hold x in the low bits, matching the packed layout.
    always_comb begin
        tri_cfg.a = rti_pkg::t_vec'(r_vtx_a);
        tri_cfg.b = rti_pkg::t_vec'(r_vtx_b);
        tri_cfg.c = rti_pkg::t_vec'(r_vtx_c);
    end

    // Front end: geometry and the hit decision, no division.
    rti_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_cfg),
        .i_eps   (r_eps),
        .i_ray   (i_ray),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cls   (f_cls)
    );

    rti_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_data  (f_cls),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_cls)
    );

    // Back end: distance quotient, hit point and the output register.
    rti_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cls   (q_cls),
        .o_res   (o_res)
    );

    // A miss beat carries zero distance and a zero hit point.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.hit) |->
            (o_res.hit_distance == '0 && o_res.hit_point_x == '0
             && o_res.hit_point_y == '0 && o_res.hit_point_z == '0))
        else $error("miss result with nonzero payload");

    // Reset leaves no result beat pending.
    assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

endmodule

>>> rtl/core/rti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle front end
// Five-stage pipeline: cross and dot products, sign fix-up and hit test.
// ----------------------------------------------------------------------------
module rti_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rti_pkg::t_tri                   i_tri,
    input  logic [rti_pkg::EPS_W-1:0]       i_eps,
    rti_ray_if.sink                         i_ray,
    output logic                            o_valid,
    input  logic                            i_ready,
    output rti_pkg::t_cls                   o_cls
);

    localparam int NW = rti_pkg::NW;
    localparam int PW = rti_pkg::PW;
    localparam int QW = rti_pkg::QW;

    logic [4:0]             r_v;
    logic                   en;

    rti_pkg::t_evec         e1;
    rti_pkg::t_evec         e2;

    rti_pkg::t_vec          n1_o;
    rti_pkg::t_vec          n1_d;
    rti_pkg::t_vec          r1_o;
    rti_pkg::t_vec          r1_d;
    rti_pkg::t_evec         r1_s;

    rti_pkg::t_pvec         n2_p;
    rti_pkg::t_qvec         n2_q;
    rti_pkg::t_pvec         r2_p;
    rti_pkg::t_qvec         r2_q;
    rti_pkg::t_evec         r2_s;
    rti_pkg::t_vec          r2_o;
    rti_pkg::t_vec          r2_d;

    logic signed [NW-1:0]   n3_det, n3_nu, n3_nv, n3_nt;
    logic signed [NW-1:0]   r3_det, r3_nu, r3_nv, r3_nt;
    rti_pkg::t_vec          r3_o;
    rti_pkg::t_vec          r3_d;

    logic signed [NW-1:0]   r4_det, r4_nu, r4_nv, r4_nt;
    rti_pkg::t_vec          r4_o;
    rti_pkg::t_vec          r4_d;

    logic signed [NW:0]     uv_sum;
    logic [NW-1:0]          n5_mag;
    rti_pkg::t_cls          n5_cls;
    rti_pkg::t_cls          r5_cls;

    // The pipeline moves as a whole unless its last stage is held.
    assign en          = !r_v[4] || i_ready;
    assign i_ray.ready = en;
    assign o_valid     = r_v[4];
    assign o_cls       = r5_cls;

    assign e1 = rti_pkg::vsub(i_tri.b, i_tri.a);
    assign e2 = rti_pkg::vsub(i_tri.c, i_tri.a);

    always_comb begin
        n1_o.x = i_ray.origin_x;
        n1_o.y = i_ray.origin_y;
        n1_o.z = i_ray.origin_z;
        n1_d.x = i_ray.dir_x;
        n1_d.y = i_ray.dir_y;
        n1_d.z = i_ray.dir_z;
    end

    // p = d x e2, q = s x e1
    always_comb begin
        n2_p.x = PW'(r1_d.y) * PW'(e2.z) - PW'(r1_d.z) * PW'(e2.y);
        n2_p.y = PW'(r1_d.z) * PW'(e2.x) - PW'(r1_d.x) * PW'(e2.z);
        n2_p.z = PW'(r1_d.x) * PW'(e2.y) - PW'(r1_d.y) * PW'(e2.x);
        n2_q.x = QW'(r1_s.y) * QW'(e1.z) - QW'(r1_s.z) * QW'(e1.y);
        n2_q.y = QW'(r1_s.z) * QW'(e1.x) - QW'(r1_s.x) * QW'(e1.z);
        n2_q.z = QW'(r1_s.x) * QW'(e1.y) - QW'(r1_s.y) * QW'(e1.x);
    end

    // Determinant and the three numerators.
    always_comb begin
        n3_det = NW'(e1.x) * NW'(r2_p.x) + NW'(e1.y) * NW'(r2_p.y)
               + NW'(e1.z) * NW'(r2_p.z);
        n3_nu  = NW'(r2_s.x) * NW'(r2_p.x) + NW'(r2_s.y) * NW'(r2_p.y)
               + NW'(r2_s.z) * NW'(r2_p.z);
        n3_nv  = NW'(r2_d.x) * NW'(r2_q.x) + NW'(r2_d.y) * NW'(r2_q.y)
               + NW'(r2_d.z) * NW'(r2_q.z);
        n3_nt  = NW'(e2.x) * NW'(r2_q.x) + NW'(e2.y) * NW'(r2_q.y)
               + NW'(e2.z) * NW'(r2_q.z);
    end

    // Hit test on the sign-corrected values; the saturation test stands in
    // for the quotient bits above the result range.
    always_comb begin
        uv_sum = (NW+1)'(r4_nu) + (NW+1)'(r4_nv);
        n5_mag = r4_nt[NW-1] ? NW'(-r4_nt) : NW'(r4_nt);
        n5_cls.side.hit = (r4_det > $signed({{(NW-rti_pkg::EPS_W){1'b0}}, i_eps}))
                       && !r4_nu[NW-1] && (r4_nu <= r4_det)
                       && !r4_nv[NW-1] && (uv_sum <= (NW+1)'(r4_det));
        n5_cls.side.sat = ({{rti_pkg::SAT_SH{1'b0}}, n5_mag})
                       >= ({{rti_pkg::SAT_SH{1'b0}}, r4_det} << rti_pkg::SAT_SH);
        n5_cls.side.neg    = r4_nt[NW-1];
        n5_cls.side.origin = r4_o;
        n5_cls.side.dir    = r4_d;
        n5_cls.det         = r4_det;
        n5_cls.mag         = n5_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[3:0], i_ray.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_o   <= n1_o;
            r1_d   <= n1_d;
            r1_s   <= rti_pkg::vsub(n1_o, i_tri.a);
            r2_p   <= n2_p;
            r2_q   <= n2_q;
            r2_s   <= r1_s;
            r2_o   <= r1_o;
            r2_d   <= r1_d;
            r3_det <= n3_det;
            r3_nu  <= n3_nu;
            r3_nv  <= n3_nv;
            r3_nt  <= n3_nt;
            r3_o   <= r2_o;
            r3_d   <= r2_d;
            if (r3_det[NW-1]) begin
                r4_det <= -r3_det;
                r4_nu  <= -r3_nu;
                r4_nv  <= -r3_nv;
                r4_nt  <= -r3_nt;
            end else begin
                r4_det <= r3_det;
                r4_nu  <= r3_nu;
                r4_nv  <= r3_nv;
                r4_nt  <= r3_nt;
            end
            r4_o   <= r3_o;
            r4_d   <= r3_d;
            r5_cls <= n5_cls;
        end
    end

endmodule

>>> rtl/core/rti_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle classification queue
// Small FIFO that lets the front and back ends stall independently.
// ----------------------------------------------------------------------------
module rti_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_valid,
    output logic            o_wr_ready,
    input  rti_pkg::t_cls   i_wr_data,
    output logic            o_rd_valid,
    input  logic            i_rd_ready,
    output rti_pkg::t_cls   o_rd_data
);

    localparam int PW = rti_pkg::QPTR_W;

    rti_pkg::t_cls  r_mem [0:rti_pkg::QDEPTH-1];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_cnt;
    logic           push;
    logic           pop;

    assign o_wr_ready = r_cnt != (PW+1)'(rti_pkg::QDEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign o_rd_data  = r_mem[r_rd];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(rti_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(rti_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

    // The fill count never runs past the depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(rti_pkg::QDEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/core/rti_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle back end
// Pipelined restoring divider for t, then the hit point and the result beat.
// ----------------------------------------------------------------------------
module rti_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rti_pkg::t_cls   i_cls,
    rti_res_if.source       o_res
);

    localparam int DIV_N = rti_pkg::DIV_N;
    localparam int NW    = rti_pkg::NW;
    localparam int RMW   = rti_pkg::RMW;
    localparam int RW    = rti_pkg::RW;
    localparam int MW    = rti_pkg::MW;
    localparam int SW    = rti_pkg::SW;
    localparam int CF    = rti_pkg::CF;
    localparam int RF    = rti_pkg::RF;
    localparam int LAST  = DIV_N + 3;

    logic [LAST:0]          r_v;
    logic                   en;

    rti_pkg::t_side         r_side [0:DIV_N];
    logic [DIV_N-1:0]       r_quo  [0:DIV_N];
    logic [RMW-1:0]         r_rem  [0:DIV_N-1];
    logic [NW-1:0]          r_det  [0:DIV_N-1];
    logic [NW-1:0]          r_mag  [0:DIV_N-1];

    logic signed [RW-1:0]   n_t;
    logic signed [RW-1:0]   r_t;
    rti_pkg::t_side         r_t_side;

    logic signed [MW-1:0]   r_prod_x, r_prod_y, r_prod_z;
    logic                   r_m_hit;
    rti_pkg::t_vec          r_m_o;

    logic signed [SW-1:0]   sum_x, sum_y, sum_z;
    logic                   r_out_hit;
    logic signed [RW-1:0]   r_out_t;
    logic signed [RW-1:0]   r_out_x, r_out_y, r_out_z;
    logic signed [RW-1:0]   r_m_t;

    assign en      = !r_v[LAST] || o_res.ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAST-1:0], i_valid};
        end
    end

    // The partial remainder starts with the numerator bits above the result
    // range; the front end has already flagged quotients that overflow it.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= i_cls.side;
            r_quo[0]  <= '0;
            r_rem[0]  <= RMW'(i_cls.mag >> rti_pkg::SAT_SH);
            r_det[0]  <= i_cls.det;
            r_mag[0]  <= i_cls.mag;
        end
    end

    for (genvar k = 1; k <= DIV_N; k++) begin : g_div
        localparam int J = DIV_N - k;
        logic           in_bit;
        logic [RMW-1:0] trial;
        logic           ge;

        // Numerator bit J: the magnitude shifted up by the result fraction.
        if (J >= RF) begin : g_bit
            assign in_bit = r_mag[k-1][J-RF];
        end else begin : g_zero
            assign in_bit = 1'b0;
        end

        assign trial = {r_rem[k-1][RMW-2:0], in_bit};
        assign ge    = trial >= {1'b0, r_det[k-1]};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[k] <= r_side[k-1];
                r_quo[k]  <= {r_quo[k-1][DIV_N-2:0], ge};
            end
        end

        if (k < DIV_N) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[k] <= ge ? trial - {1'b0, r_det[k-1]} : trial;
                    r_det[k] <= r_det[k-1];
                    r_mag[k] <= r_mag[k-1];
                end
            end
        end
    end

    always_comb begin
        if (!r_side[DIV_N].hit) begin
            n_t = '0;
        end else if (r_side[DIV_N].sat) begin
            n_t = r_side[DIV_N].neg ? rti_pkg::T_MIN : rti_pkg::T_MAX;
        end else if (r_side[DIV_N].neg) begin
            n_t = -$signed({1'b0, r_quo[DIV_N]});
        end else begin
            n_t = $signed({1'b0, r_quo[DIV_N]});
        end
    end

    always_comb begin
        sum_x = (SW'(r_m_o.x) <<< (RF - CF)) + SW'(r_prod_x >>> CF);
        sum_y = (SW'(r_m_o.y) <<< (RF - CF)) + SW'(r_prod_y >>> CF);
        sum_z = (SW'(r_m_o.z) <<< (RF - CF)) + SW'(r_prod_z >>> CF);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t       <= n_t;
            r_t_side  <= r_side[DIV_N];
            r_prod_x  <= MW'(r_t) * MW'(r_t_side.dir.x);
            r_prod_y  <= MW'(r_t) * MW'(r_t_side.dir.y);
            r_prod_z  <= MW'(r_t) * MW'(r_t_side.dir.z);
            r_m_hit   <= r_t_side.hit;
            r_m_o     <= r_t_side.origin;
            r_m_t     <= r_t;
            r_out_hit <= r_m_hit;
            r_out_t   <= r_m_t;
            r_out_x   <= r_m_hit ? rti_pkg::sat_res(sum_x) : '0;
            r_out_y   <= r_m_hit ? rti_pkg::sat_res(sum_y) : '0;
            r_out_z   <= r_m_hit ? rti_pkg::sat_res(sum_z) : '0;
        end
    end

    assign o_res.valid        = r_v[LAST];
    assign o_res.hit          = r_out_hit;
    assign o_res.hit_distance = r_out_t;
    assign o_res.hit_point_x  = r_out_x;
    assign o_res.hit_point_y  = r_out_y;
    assign o_res.hit_point_z  = r_out_z;

endmodule

>>> bench/ray_triangle_intersect_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/triangle intersection core testbench
// Streams rays through the core against a number of triangles and threshold
// settings, predicts every result with an exact wide-integer intersection
// model and checks each result beat field by field, under varying amounts
// of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core_tb;

    localparam int RW        = rti_pkg::RW;
    localparam int CF        = rti_pkg::CF;
    localparam int RF        = rti_pkg::RF;
    localparam int CFG_W     = rti_pkg::CFG_W;
    localparam int CFG_IDX_W = rti_pkg::CFG_IDX_W;

    // One expected or observed intersection result.
    typedef struct {
        logic                 hit;
        logic signed [RW-1:0] distance;
        logic signed [RW-1:0] px;
        logic signed [RW-1:0] py;
        logic signed [RW-1:0] pz;
    } t_isect;

    typedef logic signed [127:0] t_wint;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    rti_ray_if ray_ch ();
    rti_res_if res_ch ();

    ray_triangle_intersect_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ray      (ray_ch.sink),
        .o_res      (res_ch.source)
    );

    // Shadow copy of the triangle and threshold registers.
    rti_pkg::t_vec tri_a;
    rti_pkg::t_vec tri_b;
    rti_pkg::t_vec tri_c;
    logic [15:0]   det_eps;

    t_isect expected_results[$];
    int     error_count;
    int     rays_sent;
    int     hits_seen;
    int     misses_seen;
    int     quiet_cycles;
    int     send_idle_pct;
    int     recv_stall_pct;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Clamp a wide value into the signed result range.
    function automatic logic signed [RW-1:0] clamp_result(input t_wint x);
        if (x > t_wint'(rti_pkg::T_MAX)) begin
            return rti_pkg::T_MAX;
        end else if (x < t_wint'(rti_pkg::T_MIN)) begin
            return rti_pkg::T_MIN;
        end
        return x[RW-1:0];
    endfunction

    // Exact Moller-Trumbore without division for the decision. All products
    // are formed at 128 bits, far above the widest intermediate.
    function automatic t_isect compute_intersection(input rti_pkg::t_vec o,
                                                    input rti_pkg::t_vec d);
        t_wint  va[3], vb[3], vc[3], ov[3], dv[3];
        t_wint  e1[3], e2[3], p[3], s[3], q[3];
        t_wint  det, nu, nv, nt, tmag, t, base, stp;
        t_isect r;
        va[0] = tri_a.x; va[1] = tri_a.y; va[2] = tri_a.z;
        vb[0] = tri_b.x; vb[1] = tri_b.y; vb[2] = tri_b.z;
        vc[0] = tri_c.x; vc[1] = tri_c.y; vc[2] = tri_c.z;
        ov[0] = o.x; ov[1] = o.y; ov[2] = o.z;
        dv[0] = d.x; dv[1] = d.y; dv[2] = d.z;
        r = '{hit: 1'b0, distance: '0, px: '0, py: '0, pz: '0};
        for (int i = 0; i < 3; i++) begin
            e1[i] = vb[i] - va[i];
            e2[i] = vc[i] - va[i];
            s[i]  = ov[i] - va[i];
        end
        p[0] = dv[1] * e2[2] - dv[2] * e2[1];
        p[1] = dv[2] * e2[0] - dv[0] * e2[2];
        p[2] = dv[0] * e2[1] - dv[1] * e2[0];
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
        nu  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
        nv  = dv[0] * q[0] + dv[1] * q[1] + dv[2] * q[2];
        nt  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        // Flip the signs together so the determinant is positive.
        if (det < 0) begin
            det = -det; nu = -nu; nv = -nv; nt = -nt;
        end
        if (det <= t_wint'(det_eps)) return r;
        if (nu < 0 || nu > det) return r;
        if (nv < 0 || nu + nv > det) return r;
        tmag = (nt < 0) ? -nt : nt;
        tmag = (tmag <<< RF) / det;
        t = clamp_result((nt < 0) ? -tmag : tmag);
        r.hit      = 1'b1;
        r.distance = t[RW-1:0];
        for (int i = 0; i < 3; i++) begin
            base = ov[i] <<< (RF - CF);
            stp  = (t * dv[i]) >>> CF;
            case (i)
                0: r.px = clamp_result(base + stp);
                1: r.py = clamp_result(base + stp);
                default: r.pz = clamp_result(base + stp);
            endcase
        end
        return r;
    endfunction

    function automatic rti_pkg::t_vec mk_vec(input int x, input int y, input int z);
        rti_pkg::t_vec v;
        v.x = rti_pkg::t_coord'(x);
        v.y = rti_pkg::t_coord'(y);
        v.z = rti_pkg::t_coord'(z);
        return v;
    endfunction

    function automatic rti_pkg::t_vec rand_vec_full();
        return mk_vec($urandom, $urandom, $urandom);
    endfunction

    function automatic rti_pkg::t_vec rand_vec_span(input int span);
        return mk_vec($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                      $urandom_range(2 * span) - span);
    endfunction

    // Register write at the falling edge; the shadow copy follows at once.
    task automatic write_reg(input rti_pkg::t_reg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            rti_pkg::REG_VERTEX_A: tri_a = data;
            rti_pkg::REG_VERTEX_B: tri_b = data;
            rti_pkg::REG_VERTEX_C: tri_c = data;
            rti_pkg::REG_DET_EPS:  det_eps = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_triangle(input rti_pkg::t_vec a, input rti_pkg::t_vec b,
                                input rti_pkg::t_vec c);
        write_reg(rti_pkg::REG_VERTEX_A, a);
        write_reg(rti_pkg::REG_VERTEX_B, b);
        write_reg(rti_pkg::REG_VERTEX_C, c);
    endtask

    // Offer one ray beat, with random idle cycles ahead of it, and hold it
    // until the core takes it. Valid stays high into the next call.
    task automatic send_ray(input rti_pkg::t_vec o, input rti_pkg::t_vec d);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            ray_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        ray_ch.origin_x = o.x;
        ray_ch.origin_y = o.y;
        ray_ch.origin_z = o.z;
        ray_ch.dir_x    = d.x;
        ray_ch.dir_y    = d.y;
        ray_ch.dir_z    = d.z;
        ray_ch.valid    = 1'b1;
        @(posedge i_clk);
        while (!ray_ch.ready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted result has come back,
    // then give the pipeline its full latency to show any stray beat.
    task automatic drain_results();
        @(negedge i_clk);
        ray_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A ray aimed at a point inside or near the current triangle. The
    // barycentric weights are in 1/256 and may land slightly outside.
    task automatic send_aimed_ray(input int span);
        int            u, v, k;
        int            tgt[3], org[3], dd[3];
        rti_pkg::t_vec a, b, c;
        a = tri_a; b = tri_b; c = tri_c;
        u = $urandom_range(300) - 20;
        v = $urandom_range(300 - ((u > 0) ? u : 0)) - 20;
        tgt[0] = a.x + ((u * (b.x - a.x) + v * (c.x - a.x)) >>> 8);
        tgt[1] = a.y + ((u * (b.y - a.y) + v * (c.y - a.y)) >>> 8);
        tgt[2] = a.z + ((u * (b.z - a.z) + v * (c.z - a.z)) >>> 8);
        k = $urandom_range(1, 3);
        for (int i = 0; i < 3; i++) begin
            org[i] = $urandom_range(2 * span) - span;
            dd[i]  = (tgt[i] - org[i]) * k / 2;
            if (dd[i] > 32767) dd[i] = 32767;
            if (dd[i] < -32768) dd[i] = -32768;
        end
        send_ray(mk_vec(org[0], org[1], org[2]), mk_vec(dd[0], dd[1], dd[2]));
    endtask

    // Receiver: a fresh ready decision at every falling edge.
    always @(negedge i_clk) begin
        res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predicts on each accepted ray, checks each accepted result,
    // and ends the run if the handshakes stop moving.
    always @(posedge i_clk) begin
        t_isect        got;
        t_isect        want;
        rti_pkg::t_vec o;
        rti_pkg::t_vec d;
        if (i_rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (ray_ch.valid && ray_ch.ready) begin
                o = mk_vec(ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z);
                d = mk_vec(ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z);
                expected_results.push_back(compute_intersection(o, d));
                rays_sent    = rays_sent + 1;
                quiet_cycles = 0;
            end
            if (res_ch.valid && res_ch.ready) begin
                quiet_cycles = 0;
                got = '{hit: res_ch.hit, distance: res_ch.hit_distance,
                        px: res_ch.hit_point_x, py: res_ch.hit_point_y,
                        pz: res_ch.hit_point_z};
                if (got.hit) hits_seen = hits_seen + 1;
                else misses_seen = misses_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("result beat with no ray outstanding");
                    error_count = error_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, got.hit);
                        error_count = error_count + 1;
                    end
                    if (got.distance !== want.distance) begin
                        $error("hit_distance: expected %0d, got %0d",
                               want.distance, got.distance);
                        error_count = error_count + 1;
                    end
                    if (got.px !== want.px) begin
                        $error("hit_point_x: expected %0d, got %0d", want.px, got.px);
                        error_count = error_count + 1;
                    end
                    if (got.py !== want.py) begin
                        $error("hit_point_y: expected %0d, got %0d", want.py, got.py);
                        error_count = error_count + 1;
                    end
                    if (got.pz !== want.pz) begin
                        $error("hit_point_z: expected %0d, got %0d", want.pz, got.pz);
                        error_count = error_count + 1;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no beat moved for %0d cycles", quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // The triangle out of reset: A at the origin, B at 4.0 on x, C at 4.0
    // on y, threshold one LSB. Basic hits, every kind of miss, edges and a
    // ray behind its origin, which still counts as a hit.
    task automatic test_reset_triangle();
        send_ray(mk_vec(256, 256, -256), mk_vec(0, 0, 256));     // plain hit
        send_ray(mk_vec(256, 256, 256), mk_vec(0, 0, 256));      // t negative
        send_ray(mk_vec(256, 256, 256), mk_vec(0, 0, -256));     // back face
        send_ray(mk_vec(1280, 256, -256), mk_vec(0, 0, 256));    // u beyond 1
        send_ray(mk_vec(256, -256, -256), mk_vec(0, 0, 256));    // v below 0
        send_ray(mk_vec(-256, 256, -256), mk_vec(0, 0, 256));    // u below 0
        send_ray(mk_vec(768, 768, -256), mk_vec(0, 0, 256));     // u+v beyond 1
        send_ray(mk_vec(512, 512, -256), mk_vec(0, 0, 256));     // on the long edge
        send_ray(mk_vec(0, 0, -256), mk_vec(0, 0, 256));         // on vertex A
        send_ray(mk_vec(256, 256, -256), mk_vec(256, 0, 0));     // parallel
        send_ray(mk_vec(0, 0, 0), mk_vec(0, 0, 0));              // zero direction
        send_ray(mk_vec(-32768, -32768, -32768), mk_vec(32767, 32767, 32767));
        send_ray(mk_vec(32767, 32767, 32767), mk_vec(-32768, -32768, -32768));
        send_ray(mk_vec(256, 256, 32767), mk_vec(-1, -1, -32768));
        drain_results();
    endtask

    // The threshold at zero, at a value that splits a tiny triangle's
    // determinant, and at its maximum; plus a distance that saturates.
    task automatic test_det_threshold();
        set_triangle(mk_vec(0, 0, 0), mk_vec(1, 0, 0), mk_vec(0, 1, 0));
        write_reg(rti_pkg::REG_DET_EPS, CFG_W'(0));
        send_ray(mk_vec(0, 0, -32768), mk_vec(0, 0, 1));          // saturating t
        send_ray(mk_vec(0, 0, 32767), mk_vec(0, 0, 1));
        drain_results();
        write_reg(rti_pkg::REG_DET_EPS, CFG_W'(256));
        send_ray(mk_vec(0, 0, -256), mk_vec(0, 0, 256));          // det equals threshold
        send_ray(mk_vec(0, 0, -256), mk_vec(0, 0, 257));          // just above
        send_ray(mk_vec(0, 0, -256), mk_vec(0, 0, -257));         // negative det
        drain_results();
        write_reg(rti_pkg::REG_DET_EPS, CFG_W'(16'hFFFF));
        send_ray(mk_vec(0, 0, -256), mk_vec(0, 0, 32767));
        drain_results();
        set_triangle(mk_vec(0, 0, 0), mk_vec(1024, 0, 0), mk_vec(0, 1024, 0));
        write_reg(rti_pkg::REG_DET_EPS, CFG_W'(16'hFFFF));
        send_ray(mk_vec(256, 256, -256), mk_vec(0, 0, 256));
        drain_results();
    endtask

    // Mostly aimed rays against a fresh random triangle every few dozen,
    // with a slice of fully random rays.
    task automatic test_random_rays(input int n_rays, input int idle_pct,
                                    input int stall_pct);
        int   span;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_rays; i++) begin
            if (i % 40 == 0) begin
                drain_results();
                span = ($urandom_range(3) == 0) ? 16384 : 2048;
                set_triangle(rand_vec_span(span), rand_vec_span(span), rand_vec_span(span));
                write_reg(rti_pkg::REG_DET_EPS,
                          CFG_W'(($urandom_range(3) == 0) ? $urandom : 32'd1));
            end
            if ($urandom_range(99) < 70) begin
                send_aimed_ray(span);
            end else begin
                send_ray(rand_vec_full(), rand_vec_full());
            end
        end
        drain_results();
    endtask

    // Extreme vertex registers: all ones, the most positive and most
    // negative coordinates, mixed with fully random triangles.
    task automatic test_extreme_vertices();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        write_reg(rti_pkg::REG_DET_EPS, CFG_W'(0));
        set_triangle('1, '0, {CFG_W{1'b1}});
        for (int i = 0; i < 10; i++) send_ray(rand_vec_full(), rand_vec_full());
        drain_results();
        set_triangle(mk_vec(-32768, -32768, -32768), mk_vec(32767, -32768, 32767),
                     mk_vec(-32768, 32767, 32767));
        for (int i = 0; i < 60; i++) begin
            if (i % 2 == 0) send_aimed_ray(32767);
            else send_ray(rand_vec_full(), rand_vec_full());
        end
        drain_results();
        for (int i = 0; i < 100; i++) begin
            if (i % 25 == 0) begin
                drain_results();
                set_triangle(rand_vec_full(), rand_vec_full(), rand_vec_full());
            end
            if (i % 2 == 0) send_aimed_ray(32767);
            else send_ray(rand_vec_full(), rand_vec_full());
        end
        drain_results();
    endtask

    // Back-pressure against a full pipeline, then the sender holds off
    // until everything in flight has come out before it goes on.
    task automatic test_sender_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        set_triangle(mk_vec(-1024, -1024, 0), mk_vec(1024, -1024, 256),
                     mk_vec(0, 1024, -256));
        write_reg(rti_pkg::REG_DET_EPS, CFG_W'(1));
        for (int i = 0; i < 60; i++) send_aimed_ray(2048);
        @(negedge i_clk);
        ray_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        for (int i = 0; i < 60; i++) send_aimed_ray(2048);
        drain_results();
    endtask

    initial begin
        error_count    = 0;
        rays_sent      = 0;
        hits_seen      = 0;
        misses_seen    = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tri_a          = '0;
        tri_b          = 48'd1024;
        tri_c          = 48'd67108864;
        det_eps        = 16'd1;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = rti_pkg::REG_VERTEX_A;
        i_cfg_data     = '0;
        ray_ch.valid    = 1'b0;
        ray_ch.origin_x = '0;
        ray_ch.origin_y = '0;
        ray_ch.origin_z = '0;
        ray_ch.dir_x    = '0;
        ray_ch.dir_y    = '0;
        ray_ch.dir_z    = '0;
        res_ch.ready    = 1'b1;
        i_rst_n         = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_triangle();
        test_det_threshold();
        test_random_rays(300, 0, 0);
        test_random_rays(300, 83, 0);
        test_random_rays(300, 0, 83);
        test_random_rays(300, 35, 35);
        test_extreme_vertices();
        test_sender_pause();

        $display("Covered %0d rays: %0d hits, %0d misses, over directed, random and",
                 rays_sent, hits_seen, misses_seen);
        $display("extreme triangles with idle and back-pressure phases.");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
